// ===== rtl/square_scytale_transposer_core_assert.svh =====
// Assertion macros used by the square scytale transposer datapath.
`ifndef SQUARE_SCYTALE_TRANSPOSER_CORE_ASSERT_SVH
`define SQUARE_SCYTALE_TRANSPOSER_CORE_ASSERT_SVH

// Checked on every rising edge outside reset.
`define SST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SST_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/sst_pkg.sv =====
// Package with the constants, payload types and control structs of the transposer.
package sst_pkg;

  localparam int unsigned MaxChars = 64;
  localparam int unsigned CountW   = $clog2(MaxChars + 1);
  localparam int unsigned AddrW    = $clog2(MaxChars);
  localparam int unsigned SideW    = CountW / 2 + 1;
  localparam int unsigned SqW      = 2 * SideW;

  localparam logic [7:0] PadChar = 8'h20;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
    logic       overflow;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;
    logic side_clr;
    logic side_step;
    logic issue;
    logic finish;
  } sst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic side_ok;
    logic cell_last;
    logic out_free;
  } sst_sts_t;

endpackage

// ===== rtl/sst_datapath.sv =====
// Datapath of the transposer: message memory, counters, side search and output register.
`include "square_scytale_transposer_core_assert.svh"

module sst_datapath import sst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sst_cmd_t cmd_i,
  output sst_sts_t sts_o,
  input  in_t      in_data_i,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output out_t     out_data_o
);

  logic [7:0]        mem [MaxChars];
  logic [CountW-1:0] cnt_q;
  logic              dropped_q;
  logic [SideW-1:0]  side_q;
  logic [SideW-1:0]  row_q;
  logic [SideW-1:0]  col_q;
  logic [SqW-1:0]    idx_q;
  logic              out_valid_q;
  out_t              out_q;

  logic [SqW-1:0]    side_sq;
  logic [SideW-1:0]  side_m1;
  logic              not_full;

  assign side_sq  = SqW'(side_q) * SqW'(side_q);
  assign side_m1  = side_q - SideW'(1);
  assign not_full = cnt_q < CountW'(MaxChars);

  assign sts_o.side_ok   = side_sq >= SqW'(cnt_q);
  assign sts_o.cell_last = (row_q == side_m1) && (col_q == side_m1);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      dropped_q   <= 1'b0;
      side_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.store) begin
        if (not_full) begin
          cnt_q <= cnt_q + CountW'(1);
        end else begin
          dropped_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        cnt_q     <= '0;
        dropped_q <= 1'b0;
      end
      if (cmd_i.side_clr) begin
        side_q <= '0;
        row_q  <= '0;
        col_q  <= '0;
        idx_q  <= '0;
      end else if (cmd_i.side_step) begin
        side_q <= side_q + SideW'(1);
      end
      // Walk the square column by column; the linear index moves by one row
      // (side entries) per step and restarts at the next column's top.
      if (cmd_i.issue) begin
        if (row_q == side_m1) begin
          row_q <= '0;
          col_q <= col_q + SideW'(1);
          idx_q <= SqW'(col_q) + SqW'(1);
        end else begin
          row_q <= row_q + SideW'(1);
          idx_q <= idx_q + SqW'(side_q);
        end
      end
      if (cmd_i.issue) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Memory write port and registered read straight into the output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && not_full) begin
      mem[cnt_q[AddrW-1:0]] <= in_data_i.in_char;
    end
    if (cmd_i.issue) begin
      out_q.out_char <= (idx_q < SqW'(cnt_q)) ? mem[idx_q[AddrW-1:0]] : PadChar;
      out_q.out_last <= sts_o.cell_last;
      out_q.overflow <= dropped_q;
    end
  end

  `SST_ASSERT(a_count_range, cnt_q <= CountW'(MaxChars), "byte count exceeds buffer size")
  `SST_ASSERT(a_drop_when_full, dropped_q |-> (cnt_q == CountW'(MaxChars)), "early drop flag")
  `SST_ASSERT(a_finish_clears, cmd_i.finish |=> (cnt_q == '0 && !dropped_q), "message state not cleared")
  `SST_ASSERT(a_step_only_short, cmd_i.side_step |-> !sts_o.side_ok, "side stepped past ceiling root")
  `SST_ASSERT(a_issue_side, cmd_i.issue |-> (side_q != '0), "emit with zero side")
  `SST_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_q, "output valid after reset")

endmodule

// ===== rtl/sst_ctrl.sv =====
// Controller state machine of the transposer: load, side search and emit phases.
module sst_ctrl import sst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  input  sst_sts_t sts_i,
  output sst_cmd_t cmd_o
);

  localparam logic [1:0] StLoad = 2'd0;
  localparam logic [1:0] StSide = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StLoad: begin
        in_ready_o  = 1'b1;
        cmd_o.store = in_valid_i;
        if (in_valid_i && in_last_i) begin
          cmd_o.side_clr = 1'b1;
          state_d        = StSide;
        end
      end
      StSide: begin
        if (sts_i.side_ok) begin
          state_d = StEmit;
        end else begin
          cmd_o.side_step = 1'b1;
        end
      end
      StEmit: begin
        cmd_o.issue = sts_i.out_free;
        if (sts_i.out_free && sts_i.cell_last) begin
          cmd_o.finish = 1'b1;
          state_d      = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/square_scytale_transposer_core.sv =====
// Top level of the square scytale transposer: controller plus datapath.
// The input channel takes one message byte per transaction, with in_last set
// on the final byte. Bytes are stored in arrival order, one per cycle, in a
// 64-entry buffer; bytes arriving while the buffer is full are dropped and the
// whole message is flagged with overflow.
// After the last byte the block finds the side of the square, the smallest
// number whose square covers the stored length, by stepping a counter and
// squaring it. It then emits side*side output transactions, reading the
// square column by column, padding empty cells with spaces and setting
// out_last on the final one. Emission runs at one transaction per cycle
// while the receiver does not stall, set by the single memory read port that
// feeds the output register, which takes the first cell after side search.
// The input channel is not ready during side search and emission; it opens
// again in the cycle after the last cell is issued, even while that cell
// still waits in the output register.
// A receiver stall holds the output register and pauses the column walk.
// Reset clears the counters, the drop flag and the output valid; the buffer
// contents are not cleared, since only written entries are ever read.
module square_scytale_transposer_core import sst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  sst_cmd_t cmd;
  sst_sts_t sts;

  sst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.in_last),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sst_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/square_scytale_transposer_core_checker.sv =====
// Checker that predicts the transposed squares and compares every output transaction.
module square_scytale_transposer_core_checker import sst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  output int unsigned fail_count_o,
  output int unsigned cells_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  msg_buf [MaxChars];
  int unsigned msg_len;
  logic        msg_dropped;
  out_t        cells_due [$];
  out_t        want;
  int unsigned fails;

  function automatic int unsigned square_side(int unsigned len);
    int unsigned s;
    s = 0;
    while (s * s < len) s++;
    return s;
  endfunction

  // Queues the whole square, read column by column, for the message held now.
  task automatic queue_square();
    int unsigned side;
    int unsigned idx;
    out_t        entry;
    side = square_side(msg_len);
    for (int unsigned col = 0; col < side; col++) begin
      for (int unsigned row = 0; row < side; row++) begin
        idx            = row * side + col;
        entry.out_char = (idx < msg_len) ? msg_buf[idx] : PadChar;
        entry.out_last = (col == side - 1) && (row == side - 1);
        entry.overflow = msg_dropped;
        cells_due.push_back(entry);
      end
    end
  endtask

  task automatic report_field(string field, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, field, exp_val, act_val);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_len     = 0;
      msg_dropped = 1'b0;
      fails       = 0;
      cells_due.delete();
    end else begin
      // Results leave before the new byte is folded in; the queue keeps order.
      if (out_valid_i && out_ready_i) begin
        if (cells_due.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual char 0x%0h last %0b ovf %0b",
                   $time, out_data_i.out_char, out_data_i.out_last, out_data_i.overflow);
          fails++;
        end else begin
          want = cells_due.pop_front();
          report_field("out_char", 32'(want.out_char), 32'(out_data_i.out_char));
          report_field("out_last", 32'(want.out_last), 32'(out_data_i.out_last));
          report_field("overflow", 32'(want.overflow), 32'(out_data_i.overflow));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (msg_len < MaxChars) begin
          msg_buf[msg_len] = in_data_i.in_char;
          msg_len++;
        end else begin
          msg_dropped = 1'b1;
        end
        if (in_data_i.in_last) begin
          queue_square();
          msg_len     = 0;
          msg_dropped = 1'b0;
        end
      end
    end
    fail_count_o <= fails;
    cells_due_o  <= cells_due.size();
  end

endmodule

// ===== tb/square_scytale_transposer_core_test.sv =====
// Top of the transposer testbench: clock, reset, message stimulus and verdict.
module square_scytale_transposer_core_test import sst_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Roughly this many bytes are sent; from CalmFrom on nobody idles.
  localparam int unsigned ItemTarget = 470;
  localparam int unsigned CalmFrom   = 400;
  // Cycles without any transaction before the run is declared hung. The
  // slowest legal gap is a sender pause, a side search and a receiver stall.
  localparam int unsigned WatchLimit = 2000;
  localparam int unsigned TailCycles = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  int unsigned fail_count;
  int unsigned cells_due;

  int unsigned items_sent = 0;
  bit          calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  square_scytale_transposer_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  square_scytale_transposer_core_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .cells_due_o (cells_due)
  );

  // The receiver stalls in random bursts until the calm tail of
  // the run. The ready level for the next cycle is worked out first, so the
  // signal gets exactly one update per edge.
  always @(posedge clk_i) begin
    logic rdy;
    rdy = 1'b1;
    if (stall_left != 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      rdy = 1'b0;
    end
    out_ready_i <= rdy;
  end

  // Watchdog: counts cycles in which neither channel completes a transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchLimit) begin
        $display("square_scytale_transposer_core regression: fail");
        $finish;
      end
    end
  end

  // Bytes lean toward the two extremes so that every bit is seen both ways
  // early, and plain random values fill the rest.
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) begin
      return 8'h00;
    end else if (r == 1) begin
      return 8'hFF;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one byte and returns at the edge where it is accepted. Before the
  // byte the sender may go idle for a burst; valid then drops for that burst.
  // Once raised, valid and the payload hold until the transaction completes.
  task automatic send_byte(input logic [7:0] ch, input logic last);
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{in_char: ch, in_last: last};
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (items_sent >= CalmFrom) calm = 1'b1;
  endtask

  // A message of len bytes with random content; only the final one is last.
  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(pick_byte(), i == len - 1);
    end
  endtask

  // Holds the input side idle until every predicted cell has come out. The
  // checker's count is registered, so the first look waits for the next edge.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (cells_due != 0);
  endtask

  initial begin
    int unsigned msg_no;
    int unsigned len;
    int unsigned r;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. One-byte squares with the lowest and highest byte, a
    // two-byte message that needs padding, a perfect square, a length just
    // past a square, and a three-by-three square.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b1);
    send_message(4);
    send_message(5);
    send_message(9);

    // Let the block finish completely before the random part starts.
    wait_drained();

    // Random part. The first messages hit an exactly full buffer, one byte
    // too many (the dropped byte is the last one) and several bytes too many.
    // After that most messages are short, some fill a good part of the
    // buffer, and a few run past its end.
    msg_no = 0;
    while (items_sent < ItemTarget) begin
      if (msg_no == 0) begin
        len = MaxChars;
      end else if (msg_no == 1) begin
        len = MaxChars + 1;
      end else if (msg_no == 2) begin
        len = MaxChars + 8;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          len = $urandom_range(1, 16);
        end else if (r < 90) begin
          len = $urandom_range(17, MaxChars);
        end else begin
          len = $urandom_range(MaxChars + 1, MaxChars + 16);
        end
      end
      send_message(len);
      // One more full drain in the middle of the run.
      if (msg_no == 5) wait_drained();
      msg_no++;
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0 && cells_due == 0) begin
      $display("square_scytale_transposer_core regression: pass");
    end else begin
      $display("square_scytale_transposer_core regression: fail");
    end
    $finish;
  end

endmodule
